// File: hdl/slpg_pkg.sv
// Shared types, constants and helper functions for the status LED pattern generator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package slpg_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_BLIP     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        MODE_BOOT     = 3'd0,
        MODE_CONNECT  = 3'd1,
        MODE_NOSERVER = 3'd2,
        MODE_STREAM   = 3'd3,
        MODE_ERROR    = 3'd4,
        MODE_NONE     = 3'd5
    } mode_t;

    localparam logic [0:0] REG_MAX_BRIGHTNESS = 1'd0;
    localparam logic [0:0] REG_CAP_ENABLE     = 1'd1;

    localparam logic [7:0] MAX_BRIGHTNESS_RESET = 8'd64;
    localparam logic       CAP_ENABLE_RESET     = 1'b1;

    localparam logic [7:0] LEVEL_FULL   = 8'd255;
    localparam logic [7:0] LEVEL_DIM    = 8'd20;
    localparam logic [7:0] LEVEL_IDLE   = 8'd40;
    localparam logic [7:0] LEVEL_OFF    = 8'd0;
    localparam logic [7:0] LED_ON_LIMIT = 8'd127;

    localparam logic [1:0] BLIP_TICKS = 2'd2;

    // Phase periods of the animations.
    localparam logic [5:0] BOOT_PERIOD    = 6'd40;
    localparam logic [5:0] BOOT_HALF      = 6'd20;
    localparam logic [4:0] CONNECT_PERIOD = 5'd20;
    localparam logic [4:0] CONNECT_HALF   = 5'd10;
    localparam logic [4:0] NOSRV_PERIOD   = 5'd30;

    typedef struct packed {
        logic [7:0] max_brightness;
        logic       cap_enable;
    } cfg_t;

    // One tick job handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] env;
        mode_t      mode;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    function automatic rgb_t mode_rgb(input mode_t m);
        rgb_t c;
        unique case (m)
            MODE_BOOT:     c = '{r: 8'd255, g: 8'd255, b: 8'd255};
            MODE_CONNECT:  c = '{r: 8'd0,   g: 8'd80,  b: 8'd255};
            MODE_NOSERVER: c = '{r: 8'd255, g: 8'd140, b: 8'd0};
            MODE_STREAM:   c = '{r: 8'd0,   g: 8'd255, b: 8'd60};
            default:       c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
        endcase
        return c;
    endfunction

    // Ramp of the boot breathing animation: d*255/20 for d in 0..20.
    function automatic logic [7:0] boot_ramp(input logic [4:0] d);
        logic [7:0] v;
        unique case (d)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd12;
            5'd2:  v = 8'd25;
            5'd3:  v = 8'd38;
            5'd4:  v = 8'd51;
            5'd5:  v = 8'd63;
            5'd6:  v = 8'd76;
            5'd7:  v = 8'd89;
            5'd8:  v = 8'd102;
            5'd9:  v = 8'd114;
            5'd10: v = 8'd127;
            5'd11: v = 8'd140;
            5'd12: v = 8'd153;
            5'd13: v = 8'd165;
            5'd14: v = 8'd178;
            5'd15: v = 8'd191;
            5'd16: v = 8'd204;
            5'd17: v = 8'd216;
            5'd18: v = 8'd229;
            5'd19: v = 8'd242;
            5'd20: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // Exact x/255 for any product of two 8-bit values.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// File: hdl/slpg_front.sv
// Front end: accepts events, keeps the mode, blip and tick state, and computes the envelope.
// Depends on slpg_pkg; feeds tick jobs into slpg_queue.
`timescale 1ns / 1ps

module slpg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [2:0]           s_new_mode,
    input  slpg_pkg::queue_stat_t q_stat,
    output logic                 job_push,
    output slpg_pkg::job_t       job
);
    import slpg_pkg::*;

    mode_t       requested_mode_reg, requested_mode_next;
    mode_t       shown_mode_reg, shown_mode_next;
    logic [31:0] tick_count_reg, tick_count_next;
    logic [1:0]  blip_count_reg, blip_count_next;
    // Phase counters track tick_count modulo 40, 30 and 20.
    logic [5:0]  p40_reg, p40_next;
    logic [4:0]  p30_reg, p30_next;
    logic [4:0]  p20_reg, p20_next;

    logic        accept;
    logic        restart;
    logic [31:0] t_eff;
    logic [5:0]  p40;
    logic [4:0]  p30;
    logic [4:0]  p20;
    logic [5:0]  boot_dist;
    logic [7:0]  env;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    assign restart   = (requested_mode_reg != shown_mode_reg);
    assign t_eff     = restart ? 32'd0 : tick_count_reg;
    assign p40       = restart ? 6'd0 : p40_reg;
    assign p30       = restart ? 5'd0 : p30_reg;
    assign p20       = restart ? 5'd0 : p20_reg;
    assign boot_dist = (p40 < BOOT_HALF) ? p40 : (BOOT_PERIOD - p40);

    always_comb begin
        unique case (requested_mode_reg)
            MODE_BOOT:     env = boot_ramp(boot_dist[4:0]);
            MODE_CONNECT:  env = (p20 < CONNECT_HALF) ? LEVEL_FULL : LEVEL_DIM;
            MODE_NOSERVER: env = (p30 < 5'd3 || (p30 >= 5'd6 && p30 < 5'd9))
                                 ? LEVEL_FULL : LEVEL_OFF;
            MODE_STREAM:   env = (blip_count_reg != 2'd0) ? LEVEL_FULL : LEVEL_IDLE;
            default:       env = (p20 < 5'd2 || (p20 >= 5'd4 && p20 < 5'd6))
                                 ? LEVEL_FULL : LEVEL_OFF;
        endcase
    end

    always_comb begin
        requested_mode_next = requested_mode_reg;
        shown_mode_next     = shown_mode_reg;
        tick_count_next     = tick_count_reg;
        blip_count_next     = blip_count_reg;
        p40_next            = p40_reg;
        p30_next            = p30_reg;
        p20_next            = p20_reg;
        job_push            = 1'b0;
        if (accept) begin
            unique case (op_t'(s_opcode))
                OP_SET_MODE: begin
                    if (s_new_mode < MODE_NONE) begin
                        requested_mode_next = mode_t'(s_new_mode);
                    end
                end
                OP_BLIP: begin
                    blip_count_next = BLIP_TICKS;
                end
                OP_TICK: begin
                    job_push        = 1'b1;
                    shown_mode_next = requested_mode_reg;
                    tick_count_next = t_eff + 32'd1;
                    if (blip_count_reg != 2'd0) begin
                        blip_count_next = blip_count_reg - 2'd1;
                    end
                    // The phases restart when the 32-bit counter wraps to zero.
                    if (t_eff == '1) begin
                        p40_next = 6'd0;
                        p30_next = 5'd0;
                        p20_next = 5'd0;
                    end else begin
                        p40_next = (p40 == BOOT_PERIOD - 6'd1) ? 6'd0 : p40 + 6'd1;
                        p30_next = (p30 == NOSRV_PERIOD - 5'd1) ? 5'd0 : p30 + 5'd1;
                        p20_next = (p20 == CONNECT_PERIOD - 5'd1) ? 5'd0 : p20 + 5'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign job.env  = env;
    assign job.mode = requested_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            requested_mode_reg <= MODE_BOOT;
            shown_mode_reg     <= MODE_NONE;
            tick_count_reg     <= 32'd0;
            blip_count_reg     <= 2'd0;
            p40_reg            <= 6'd0;
            p30_reg            <= 5'd0;
            p20_reg            <= 5'd0;
        end else begin
            requested_mode_reg <= requested_mode_next;
            shown_mode_reg     <= shown_mode_next;
            tick_count_reg     <= tick_count_next;
            blip_count_reg     <= blip_count_next;
            p40_reg            <= p40_next;
            p30_reg            <= p30_next;
            p20_reg            <= p20_next;
        end
    end

endmodule

// File: hdl/slpg_queue.sv
// Short first-in first-out queue of tick jobs between the front end and the back end.
// Depends on slpg_pkg for the job and status types.
`timescale 1ns / 1ps

module slpg_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  slpg_pkg::job_t        push_job,
    input  logic                  pop,
    output slpg_pkg::job_t        pop_job,
    output slpg_pkg::queue_stat_t stat
);
    import slpg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/slpg_back.sv
// Back end: brightness cap and colour scaling of tick jobs, ending in the result register.
// Depends on slpg_pkg for the job type, the colour table and the divide-by-255 helper.
`timescale 1ns / 1ps

module slpg_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  slpg_pkg::cfg_t        cfg,
    input  slpg_pkg::queue_stat_t q_stat,
    input  slpg_pkg::job_t        q_job,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_level,
    output logic                  m_led_on,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue
);
    import slpg_pkg::*;

    logic        advance;
    logic        s1_valid_reg;
    logic [7:0]  s1_env_reg;
    mode_t       s1_mode_reg;
    logic [15:0] s1_prod_reg;
    logic        s2_valid_reg;
    logic [7:0]  s2_level_reg;
    mode_t       s2_mode_reg;
    logic        s3_valid_reg;
    logic [7:0]  s3_level_reg;
    logic [15:0] s3_r_reg;
    logic [15:0] s3_g_reg;
    logic [15:0] s3_b_reg;
    logic        out_valid_reg;
    logic [7:0]  out_level_reg;
    logic        out_led_on_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    logic [7:0]  s2_level_next;
    rgb_t        s2_rgb;

    // The whole pipe moves together whenever the result register can take a value.
    assign advance = !out_valid_reg || m_ready;
    assign q_pop   = advance && !q_stat.empty;

    assign s2_level_next = s1_env_reg;
    assign s2_rgb        = mode_rgb(s2_mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_env_reg   <= q_job.env;
            s1_mode_reg  <= q_job.mode;
            s1_prod_reg  <= 16'(q_job.env) * 16'(cfg.max_brightness);
            s2_mode_reg  <= s1_mode_reg;
            s2_level_reg <= cfg.cap_enable ? div255(s1_prod_reg) : s2_level_next;
            s3_level_reg <= s2_level_reg;
            s3_r_reg     <= 16'(s2_rgb.r) * 16'(s2_level_reg);
            s3_g_reg     <= 16'(s2_rgb.g) * 16'(s2_level_reg);
            s3_b_reg     <= 16'(s2_rgb.b) * 16'(s2_level_reg);
            out_level_reg  <= s3_level_reg;
            out_led_on_reg <= (s3_level_reg > LED_ON_LIMIT);
            out_red_reg    <= div255(s3_r_reg);
            out_green_reg  <= div255(s3_g_reg);
            out_blue_reg   <= div255(s3_b_reg);
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_level  = out_level_reg;
    assign m_led_on = out_led_on_reg;
    assign m_red    = out_red_reg;
    assign m_green  = out_green_reg;
    assign m_blue   = out_blue_reg;

endmodule

// File: hdl/status_led_pattern_generator.sv
// Status LED pattern generator. A tick result passes the job queue, stages s1, s2 and s3
// and the result register. Items are accepted at one per cycle while the job queue has
// room and results are taken. Mode requests and blips yield no result, only front-end state.
// The queue depth sets how many tick jobs may wait when the result side stalls.
// Reset (aresetn, synchronous, active low) clears mode, counters, queue and pipeline
// and restores max_brightness to 64 and cap_enable to 1. No clearing pass is needed.
`timescale 1ns / 1ps

module status_led_pattern_generator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Event input channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [2:0] s_new_mode,
    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_level,
    output logic       m_led_on,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import slpg_pkg::*;

    // Configuration registers. Writes are always taken; software must change them only while
    // the block is idle, as the back end reads them directly. The block does not enforce this.
    logic [7:0]  max_brightness_reg;
    logic        cap_enable_reg;
    cfg_t        cfg;

    // Front-to-queue and queue-to-back connections.
    logic        job_push;
    job_t        push_job;
    job_t        pop_job;
    logic        job_pop;
    queue_stat_t q_stat;

    assign cfg_ready          = 1'b1;
    assign cfg.max_brightness = max_brightness_reg;
    assign cfg.cap_enable     = cap_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_brightness_reg <= MAX_BRIGHTNESS_RESET;
            cap_enable_reg     <= CAP_ENABLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_BRIGHTNESS: max_brightness_reg <= cfg_data;
                REG_CAP_ENABLE:     cap_enable_reg     <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each item, updates the mode, blip and tick
    // state at once, and turns a tick into a job carrying its raw envelope.
    slpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_new_mode (s_new_mode),
        .q_stat     (q_stat),
        .job_push   (job_push),
        .job        (push_job)
    );

    // The queue lets the front end keep taking items while results stall.
    slpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    // The back end applies the cap and scales the mode colour, with the cap product in s1
    // and the colour products in s3, and holds the finished item for the sink.
    slpg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .q_job    (pop_job),
        .q_pop    (job_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_level  (m_level),
        .m_led_on (m_led_on),
        .m_red    (m_red),
        .m_green  (m_green),
        .m_blue   (m_blue)
    );

`ifndef SYNTHESIS
    // The on/off drive must agree with the level shown.
    a_led_on_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_led_on == m_level[7]))
        else $error("led_on does not match level");

    // With the cap on, the shown level never exceeds the cap.
    a_level_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && cap_enable_reg) |-> (m_level <= max_brightness_reg))
        else $error("level exceeds max_brightness");

    // A tick job is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !q_stat.full)
        else $error("tick job pushed into full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the status LED pattern generator.
// Depends on slpg_pkg and status_led_pattern_generator; predicts every tick frame in-line.
`timescale 1ns / 1ps

module tb;
    import slpg_pkg::*;

    // Opcode 3 has no meaning and must be dropped by the block.
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    // Highest value that the 3-bit mode field can carry.
    localparam logic [2:0] MODE_CODE_MAX = 3'd7;
    // A tick frame must pass the queue and the back-end stages; this leaves ample margin.
    localparam int         SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [7:0] level;
        logic       led_on;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } led_frame_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_opcode;
    logic [2:0] s_new_mode;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_level;
    logic       m_led_on;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    // Our own copy of the pattern state and settings, advanced on every accepted item.
    mode_t       want_mode;
    mode_t       shown_mode;
    int unsigned tick_count;
    logic [1:0]  blips_left;
    logic [7:0]  max_level;
    logic        cap_on;

    // Frames predicted but not yet seen on the result channel, oldest first.
    led_frame_t  frames_due[$];
    int          error_count;
    // When set, neither the sender nor the receiver inserts gaps.
    logic        gaps_off;

    status_led_pattern_generator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_new_mode (s_new_mode),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_level    (m_level),
        .m_led_on   (m_led_on),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Applies one accepted item to the predicted state. A tick yields exactly one frame:
    // the per-mode envelope, the optional cap, and the mode color scaled by level/255.
    task automatic advance_led_model(input logic [1:0] opcode, input logic [2:0] mode_code);
        int unsigned phase;
        int unsigned env;
        int unsigned lvl;
        int unsigned cr;
        int unsigned cg;
        int unsigned cb;
        led_frame_t  frame;
        case (opcode)
            OP_SET_MODE: begin
                // Values past the error mode are dropped without a trace.
                if (mode_code < MODE_NONE) begin
                    want_mode = mode_t'(mode_code);
                end
            end
            OP_BLIP: begin
                blips_left = BLIP_TICKS;
            end
            OP_TICK: begin
                // A mode change restarts the animation from its first phase.
                if (want_mode != shown_mode) begin
                    shown_mode = want_mode;
                    tick_count = 0;
                end
                case (want_mode)
                    MODE_BOOT: begin
                        // Triangle breathing over 40 ticks.
                        phase = tick_count % 40;
                        env = (phase < 20) ? phase * 255 / 20 : (40 - phase) * 255 / 20;
                        cr = 255; cg = 255; cb = 255;
                    end
                    MODE_CONNECT: begin
                        env = ((tick_count % 20) < 10) ? 255 : 20;
                        cr = 0; cg = 80; cb = 255;
                    end
                    MODE_NOSERVER: begin
                        // Two short flashes every 30 ticks.
                        phase = tick_count % 30;
                        env = (phase < 3 || (phase >= 6 && phase < 9)) ? 255 : 0;
                        cr = 255; cg = 140; cb = 0;
                    end
                    MODE_STREAM: begin
                        env = (blips_left != 0) ? 255 : 40;
                        cr = 0; cg = 255; cb = 60;
                    end
                    default: begin
                        // Error: two fast blinks every 20 ticks.
                        phase = tick_count % 20;
                        env = (phase < 2 || (phase >= 4 && phase < 6)) ? 255 : 0;
                        cr = 255; cg = 0; cb = 0;
                    end
                endcase
                lvl = cap_on ? env * max_level / 255 : env;
                frame.level  = 8'(lvl);
                frame.led_on = (lvl > 127);
                frame.red    = 8'(cr * lvl / 255);
                frame.green  = 8'(cg * lvl / 255);
                frame.blue   = 8'(cb * lvl / 255);
                frames_due.push_back(frame);
                if (blips_left != 0) begin
                    blips_left = blips_left - 1'b1;
                end
                tick_count = tick_count + 1;
            end
            default: ;
        endcase
    endtask

    // Offers one item, called and returning at a falling edge. Gaps come before valid
    // rises; once raised, valid and payload hold until the block takes the item.
    task automatic send_event(input logic [1:0] opcode, input logic [2:0] mode_code);
        while (!gaps_off && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= opcode;
        s_new_mode <= mode_code;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        advance_led_model(opcode, mode_code);
        @(negedge aclk);
    endtask

    // Waits until every predicted frame has arrived and the pipeline has emptied, so that
    // a tick job still in flight cannot meet a register write.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (frames_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes both registers back to back; valid stays high across the pair.
    task automatic write_settings(input logic [7:0] brightness, input logic enable);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_BRIGHTNESS;
        cfg_data  <= brightness;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        max_level = brightness;
        @(negedge aclk);
        cfg_index <= REG_CAP_ENABLE;
        cfg_data  <= {7'd0, enable};
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cap_on = enable;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: a mode request followed by a run of ticks with the
    // occasional blip, so that each animation is walked through many of its phases.
    // The rest is noise: any opcode, including the unused one, with any mode value.
    task automatic run_mode_sequences(input int item_budget);
        int sent;
        int run_len;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(99) < 80) begin
                send_event(OP_SET_MODE, 3'($urandom_range(MODE_ERROR)));
                run_len = $urandom_range(45, 1);
                sent = sent + 1 + run_len;
                repeat (run_len) begin
                    // The mode field is a don't-care here; it is randomized on purpose.
                    if ($urandom_range(99) < 8) begin
                        send_event(OP_BLIP, 3'($urandom_range(MODE_CODE_MAX)));
                    end else begin
                        send_event(OP_TICK, 3'($urandom_range(MODE_CODE_MAX)));
                    end
                end
            end else begin
                send_event(2'($urandom_range(OP_UNUSED)), 3'($urandom_range(MODE_CODE_MAX)));
                sent = sent + 1;
            end
        end
    endtask

    // Right after reset the block shows the boot animation under the default cap.
    task automatic test_reset_defaults();
        repeat (3) send_event(OP_TICK, 3'd0);
        wait_for_quiet();
    endtask

    // Short walk through every mode and special case with the cap switched off,
    // so that full-scale levels and the LED drive bit show up unreduced.
    task automatic test_directed_cases();
        write_settings(8'd255, 1'b0);
        send_event(OP_SET_MODE, MODE_CONNECT);
        send_event(OP_TICK, MODE_CODE_MAX);
        send_event(OP_TICK, 3'd0);
        send_event(OP_SET_MODE, MODE_NOSERVER);
        send_event(OP_TICK, 3'd0);
        send_event(OP_SET_MODE, MODE_STREAM);
        send_event(OP_TICK, 3'd0);
        // A blip lights the streaming mode for two ticks only.
        send_event(OP_BLIP, MODE_CODE_MAX);
        send_event(OP_TICK, 3'd0);
        send_event(OP_TICK, 3'd0);
        send_event(OP_TICK, 3'd0);
        send_event(OP_SET_MODE, MODE_ERROR);
        send_event(OP_TICK, 3'd0);
        // Out-of-range mode requests must leave the error mode running.
        send_event(OP_SET_MODE, MODE_NONE);
        send_event(OP_TICK, 3'd0);
        send_event(OP_SET_MODE, 3'(MODE_NONE + 1));
        send_event(OP_SET_MODE, MODE_CODE_MAX);
        // The unused opcode must be swallowed.
        send_event(OP_UNUSED, MODE_CODE_MAX);
        send_event(OP_TICK, 3'd0);
        send_event(OP_SET_MODE, MODE_BOOT);
        send_event(OP_TICK, 3'd0);
        send_event(OP_TICK, 3'd0);
        wait_for_quiet();
    endtask

    // Random traffic under a range of brightness settings, including both extremes.
    task automatic test_settings_sweep();
        logic [7:0] brightness;
        logic       enable;
        for (int setting = 0; setting < 6; setting++) begin
            case (setting)
                0: begin brightness = 8'd255; enable = 1'b1; end
                1: begin brightness = 8'd0;   enable = 1'b1; end
                2: begin brightness = 8'($urandom); enable = 1'b0; end
                3: begin brightness = 8'd128; enable = 1'b1; end
                4: begin brightness = 8'd1;   enable = 1'b1; end
                default: begin brightness = 8'($urandom); enable = 1'($urandom); end
            endcase
            write_settings(brightness, enable);
            run_mode_sequences(60);
            wait_for_quiet();
        end
    endtask

    // Back-to-back items with the result side always ready.
    task automatic test_steady_stream();
        write_settings(8'($urandom), 1'b1);
        gaps_off = 1'b1;
        run_mode_sequences(70);
        gaps_off = 1'b0;
        wait_for_quiet();
    endtask

    // The receiver stalls at random, except during the steady stretch.
    always @(negedge aclk) begin
        m_ready <= gaps_off ? 1'b1 : ($urandom_range(99) >= 26);
    end

    task automatic report_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Every accepted frame is compared with the oldest prediction.
    always @(posedge aclk) begin : frame_check
        led_frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t ns: unexpected frame, expected none, actual level %0d",
                         $time, m_level);
                error_count++;
            end else begin
                want = frames_due.pop_front();
                report_field("level",  want.level,        m_level);
                report_field("led_on", {7'd0, want.led_on}, {7'd0, m_led_on});
                report_field("red",    want.red,          m_red);
                report_field("green",  want.green,        m_green);
                report_field("blue",   want.blue,         m_blue);
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = OP_TICK;
        s_new_mode  = MODE_BOOT;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MAX_BRIGHTNESS;
        cfg_data    = 8'd0;
        gaps_off    = 1'b0;
        error_count = 0;
        want_mode   = MODE_BOOT;
        shown_mode  = MODE_NONE;
        tick_count  = 0;
        blips_left  = 2'd0;
        max_level   = MAX_BRIGHTNESS_RESET;
        cap_on      = CAP_ENABLE_RESET;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_settings_sweep();
        test_steady_stream();

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
